// ===== rtl/ssct_pkg.sv =====
// Shared constants, widths and types of the swept circle contact-time core.
package ssct_pkg;

  localparam int CoordBits    = 16;
  localparam int TimeFracBits = 16;
  localparam int TimeW        = 32;

  localparam int RadBits = CoordBits - 1;
  localparam int DiffW   = CoordBits + 1;         // start offset components
  localparam int VelW    = CoordBits + 2;         // relative motion components
  localparam int SqW     = 2 * CoordBits + 2;     // |AB|^2 and c
  localparam int AW      = 2 * CoordBits + 4;     // a = |v|^2, also signed h
  localparam int HW      = 2 * CoordBits + 3;     // |h|
  localparam int ML      = CoordBits + 2;         // split point of wide products
  localparam int DW      = AW + SqW;              // h^2, a*c, discriminant
  localparam int YW      = DW + 2 * TimeFracBits; // scaled discriminant
  localparam int SW      = YW / 2;                // square root
  localparam int RW      = YW + 1;                // square root remainder
  localparam int NW      = HW + TimeFracBits + 1; // numerator magnitude
  localparam int QX      = (NW + 1 > TimeW + 1) ? NW + 1 : TimeW + 1;

  localparam logic [TimeW-1:0] TimeMax = {1'b0, {(TimeW - 1){1'b1}}};
  localparam logic [TimeW-1:0] TimeMin = {1'b1, {(TimeW - 1){1'b0}}};

  typedef struct packed {
    logic        [RadBits-1:0]   radius_a;
    logic signed [CoordBits-1:0] a_start_x;
    logic signed [CoordBits-1:0] a_start_y;
    logic signed [CoordBits-1:0] a_end_x;
    logic signed [CoordBits-1:0] a_end_y;
    logic        [RadBits-1:0]   radius_b;
    logic signed [CoordBits-1:0] b_start_x;
    logic signed [CoordBits-1:0] b_start_y;
    logic signed [CoordBits-1:0] b_end_x;
    logic signed [CoordBits-1:0] b_end_y;
  } ssct_item_t;

  // Values that ride along the square root pipeline.
  typedef struct packed {
    logic          overlap;
    logic          go;
    logic          hpos;
    logic [HW-1:0] hmag;
    logic [AW-1:0] a;
  } ssct_side_t;

  typedef struct packed {
    logic             hit;
    logic             overlap_at_start;
    logic [TimeW-1:0] first_time;
    logic [TimeW-1:0] second_time;
    logic             saturated;
  } ssct_res_t;

endpackage

// ===== rtl/ssct_if.sv =====
// Valid/ready channel interfaces for pair beats and result beats.
interface ssct_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [ssct_pkg::RadBits-1:0]      radius_a;
  logic signed [ssct_pkg::CoordBits-1:0]    a_start_x;
  logic signed [ssct_pkg::CoordBits-1:0]    a_start_y;
  logic signed [ssct_pkg::CoordBits-1:0]    a_end_x;
  logic signed [ssct_pkg::CoordBits-1:0]    a_end_y;
  logic        [ssct_pkg::RadBits-1:0]      radius_b;
  logic signed [ssct_pkg::CoordBits-1:0]    b_start_x;
  logic signed [ssct_pkg::CoordBits-1:0]    b_start_y;
  logic signed [ssct_pkg::CoordBits-1:0]    b_end_x;
  logic signed [ssct_pkg::CoordBits-1:0]    b_end_y;

  modport source (
    output valid, radius_a, a_start_x, a_start_y, a_end_x, a_end_y,
           radius_b, b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, radius_a, a_start_x, a_start_y, a_end_x, a_end_y,
           radius_b, b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface ssct_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic                                 overlap_at_start;
  logic signed [ssct_pkg::TimeW-1:0]    first_time;
  logic signed [ssct_pkg::TimeW-1:0]    second_time;
  logic                                 saturated;

  modport source (
    output valid, hit, overlap_at_start, first_time, second_time, saturated,
    input  ready
  );
  modport sink (
    input  valid, hit, overlap_at_start, first_time, second_time, saturated,
    output ready
  );
endinterface

// ===== rtl/swept_sphere_collision_time_core.sv =====
// Top level of the swept circle contact-time core.
//
//   Channel | Dir | Beat contents
//   --------+-----+-------------------------------------------------------
//   in_i    | in  | two radii, start and end points of both circles
//   out_o   | out | hit, overlap_at_start, first_time, second_time, saturated
//
// One pair enters per cycle while in_i.ready is high; a result leaves through
// the 7-stage coefficient pipe, the 51-stage square root and the
// 55-stage divider, plus the output register.
// Reset clears only valid bits; no state is kept between pairs.
// A stall on out_o freezes the pipeline only while its last stage holds a
// result; an empty last stage lets pairs keep flowing in.
module swept_sphere_collision_time_core (
  input logic        clk_i,
  input logic        rst_ni,
  ssct_in_if.sink    in_i,
  ssct_out_if.source out_o
);

  ssct_pkg::ssct_item_t item;
  logic                 en;
  logic                 coef_v, sqrt_v, div_v, exact;
  logic [ssct_pkg::YW-1:0] y;
  logic [ssct_pkg::SW-1:0] s;
  ssct_pkg::ssct_side_t side_c, side_s;
  ssct_pkg::ssct_res_t  div_res, res_q;
  logic                 out_valid_q;

  assign item.radius_a  = in_i.radius_a;
  assign item.a_start_x = in_i.a_start_x;
  assign item.a_start_y = in_i.a_start_y;
  assign item.a_end_x   = in_i.a_end_x;
  assign item.a_end_y   = in_i.a_end_y;
  assign item.radius_b  = in_i.radius_b;
  assign item.b_start_x = in_i.b_start_x;
  assign item.b_start_y = in_i.b_start_y;
  assign item.b_end_x   = in_i.b_end_x;
  assign item.b_end_y   = in_i.b_end_y;

  assign en         = !div_v || out_o.ready || !out_valid_q;
  assign in_i.ready = en;

  ssct_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .item_i  (item),
    .valid_o (coef_v),
    .y_o     (y),
    .side_o  (side_c)
  );

  ssct_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (coef_v),
    .y_i     (y),
    .side_i  (side_c),
    .valid_o (sqrt_v),
    .s_o     (s),
    .exact_o (exact),
    .side_o  (side_s)
  );

  ssct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_v),
    .s_i     (s),
    .exact_i (exact),
    .side_i  (side_s),
    .valid_o (div_v),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_o.ready || !out_valid_q) begin
      out_valid_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_o.ready || !out_valid_q) begin
      res_q <= div_res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.hit              = res_q.hit;
  assign out_o.overlap_at_start = res_q.overlap_at_start;
  assign out_o.first_time       = res_q.first_time;
  assign out_o.second_time      = res_q.second_time;
  assign out_o.saturated        = res_q.saturated;

  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.hit |-> !out_o.overlap_at_start && !out_o.saturated
      && out_o.first_time == '0 && out_o.second_time == '0)
    else $error("miss result carries nonzero fields");

  a_overlap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overlap_at_start |-> out_o.hit && !out_o.saturated
      && out_o.first_time == '0 && out_o.second_time == '0)
    else $error("start overlap result has nonzero times");

  a_root_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.hit |-> out_o.first_time <= out_o.second_time)
    else $error("contact times out of order");

  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !div_v |-> in_i.ready)
    else $error("input stalled although the last stage is empty");

endmodule

// ===== rtl/ssct_coef.sv =====
// Quadratic coefficient and discriminant pipeline (seven stages).
module ssct_coef (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  ssct_pkg::ssct_item_t         item_i,
  output logic                         valid_o,
  output logic [ssct_pkg::YW-1:0]      y_o,
  output ssct_pkg::ssct_side_t         side_o
);

  localparam int DiffW = ssct_pkg::DiffW;
  localparam int VelW  = ssct_pkg::VelW;
  localparam int SqW   = ssct_pkg::SqW;
  localparam int AW    = ssct_pkg::AW;
  localparam int HW    = ssct_pkg::HW;
  localparam int ML    = ssct_pkg::ML;
  localparam int DW    = ssct_pkg::DW;
  localparam int YW    = ssct_pkg::YW;
  localparam int CB    = ssct_pkg::CoordBits;

  logic [6:0] vld_q;

  // Stage 1: differences.
  logic signed [DiffW-1:0] abx_q, aby_q;
  logic signed [VelW-1:0]  vx_q, vy_q;
  logic        [CB-1:0]    rab_q;
  // Stage 2: products.
  logic signed [2*VelW-1:0]     vxx_q, vyy_q;
  logic signed [2*DiffW-1:0]    abxx_q, abyy_q;
  logic signed [VelW+DiffW-1:0] hx_q, hy_q;
  logic        [2*CB-1:0]       rr_q;
  // Stage 3: sums.
  logic        [AW-1:0]  a3_q;
  logic        [SqW-1:0] ab2_q;
  logic        [2*CB-1:0] rr3_q;
  logic signed [AW-1:0]  h3_q;
  // Stage 4: flags, c and |h|.
  logic           ov4_q, az4_q, hpos4_q;
  logic [HW-1:0]  hmag4_q;
  logic [AW-1:0]  a4_q;
  logic [SqW-1:0] c4_q;
  // Stage 5: partial products.
  logic                 ov5_q, go5_q, hpos5_q;
  logic [HW-1:0]        hmag5_q;
  logic [AW-1:0]        a5_q;
  logic [HW+ML-1:0]     h2lo_q;
  logic [2*HW-ML-1:0]   h2hi_q;
  logic [AW+ML-1:0]     aclo_q;
  logic [AW+SqW-ML-1:0] achi_q;
  // Stage 6: full products.
  logic          ov6_q, go6_q, hpos6_q;
  logic [HW-1:0] hmag6_q;
  logic [AW-1:0] a6_q;
  logic [DW-1:0] h2_q, ac_q;
  // Stage 7: discriminant.
  logic [YW-1:0]        y_q;
  ssct_pkg::ssct_side_t side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abx_q <= DiffW'(item_i.b_start_x) - DiffW'(item_i.a_start_x);
      aby_q <= DiffW'(item_i.b_start_y) - DiffW'(item_i.a_start_y);
      vx_q  <= VelW'(item_i.b_end_x) - VelW'(item_i.b_start_x)
             - VelW'(item_i.a_end_x) + VelW'(item_i.a_start_x);
      vy_q  <= VelW'(item_i.b_end_y) - VelW'(item_i.b_start_y)
             - VelW'(item_i.a_end_y) + VelW'(item_i.a_start_y);
      rab_q <= CB'(item_i.radius_a) + CB'(item_i.radius_b);

      vxx_q  <= (2*VelW)'(vx_q) * (2*VelW)'(vx_q);
      vyy_q  <= (2*VelW)'(vy_q) * (2*VelW)'(vy_q);
      abxx_q <= (2*DiffW)'(abx_q) * (2*DiffW)'(abx_q);
      abyy_q <= (2*DiffW)'(aby_q) * (2*DiffW)'(aby_q);
      hx_q   <= (VelW+DiffW)'(vx_q) * (VelW+DiffW)'(abx_q);
      hy_q   <= (VelW+DiffW)'(vy_q) * (VelW+DiffW)'(aby_q);
      rr_q   <= (2*CB)'(rab_q) * (2*CB)'(rab_q);

      a3_q  <= AW'(vxx_q) + AW'(vyy_q);
      ab2_q <= SqW'(abxx_q) + SqW'(abyy_q);
      rr3_q <= rr_q;
      h3_q  <= AW'(hx_q) + AW'(hy_q);

      ov4_q   <= ab2_q <= SqW'(rr3_q);
      az4_q   <= a3_q == '0;
      hpos4_q <= !h3_q[AW-1] && (h3_q != '0);
      hmag4_q <= h3_q[AW-1] ? HW'(-h3_q) : HW'(h3_q);
      a4_q    <= a3_q;
      c4_q    <= ab2_q - SqW'(rr3_q);

      // The wide square h^2 and the wide product a*c are cut into two narrower products each.
      ov5_q   <= ov4_q;
      go5_q   <= !ov4_q && !az4_q;
      hpos5_q <= hpos4_q;
      hmag5_q <= hmag4_q;
      a5_q    <= a4_q;
      h2lo_q  <= (HW+ML)'(hmag4_q) * (HW+ML)'(hmag4_q[ML-1:0]);
      h2hi_q  <= (2*HW-ML)'(hmag4_q) * (2*HW-ML)'(hmag4_q[HW-1:ML]);
      aclo_q  <= (AW+ML)'(a4_q) * (AW+ML)'(c4_q[ML-1:0]);
      achi_q  <= (AW+SqW-ML)'(a4_q) * (AW+SqW-ML)'(c4_q[SqW-1:ML]);

      ov6_q   <= ov5_q;
      go6_q   <= go5_q;
      hpos6_q <= hpos5_q;
      hmag6_q <= hmag5_q;
      a6_q    <= a5_q;
      h2_q    <= DW'(h2lo_q) + (DW'(h2hi_q) << ML);
      ac_q    <= DW'(aclo_q) + (DW'(achi_q) << ML);

      y_q          <= YW'(h2_q - ac_q) << (2 * ssct_pkg::TimeFracBits);
      side_q.overlap <= ov6_q;
      side_q.go      <= go6_q && (h2_q >= ac_q);
      side_q.hpos    <= hpos6_q;
      side_q.hmag    <= hmag6_q;
      side_q.a       <= a6_q;
    end
  end

  assign valid_o = vld_q[6];
  assign y_o     = y_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/ssct_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with exactness flag.
module ssct_sqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [ssct_pkg::YW-1:0] y_i,
  input  ssct_pkg::ssct_side_t    side_i,
  output logic                    valid_o,
  output logic [ssct_pkg::SW-1:0] s_o,
  output logic                    exact_o,
  output ssct_pkg::ssct_side_t    side_o
);

  localparam int SW = ssct_pkg::SW;
  localparam int RW = ssct_pkg::RW;

  logic [SW-1:0]        vld_q;
  logic [RW-1:0]        rem_q   [SW];
  logic [SW-1:0]        root_q  [SW];
  ssct_pkg::ssct_side_t side_q  [SW];
  logic [RW-1:0]        rem_in  [SW];
  logic [SW-1:0]        root_in [SW];
  ssct_pkg::ssct_side_t side_in [SW];
  logic [RW-1:0]        trial   [SW];
  logic [SW-1:0]        take;

  // The remainder holds y - root^2; stage i decides root bit SW-1-i.
  always_comb begin
    rem_in[0]  = RW'(y_i);
    root_in[0] = '0;
    side_in[0] = side_i;
    for (int i = 1; i < SW; i++) begin
      rem_in[i]  = rem_q[i-1];
      root_in[i] = root_q[i-1];
      side_in[i] = side_q[i-1];
    end
    for (int i = 0; i < SW; i++) begin
      trial[i] = (RW'(root_in[i]) << (SW - i)) + (RW'(1) << (2 * (SW - 1 - i)));
      take[i]  = rem_in[i] >= trial[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < SW; i++) begin
        rem_q[i]  <= take[i] ? rem_in[i] - trial[i] : rem_in[i];
        root_q[i] <= take[i] ? (root_in[i] | (SW'(1) << (SW - 1 - i))) : root_in[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign valid_o = vld_q[SW-1];
  assign s_o     = root_q[SW-1];
  assign exact_o = rem_q[SW-1] == '0;
  assign side_o  = side_q[SW-1];

endmodule

// ===== rtl/ssct_div.sv =====
// Root numerators, two-lane pipelined floor division by a, and Q16.16 saturation.
module ssct_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [ssct_pkg::SW-1:0] s_i,
  input  logic                    exact_i,
  input  ssct_pkg::ssct_side_t    side_i,
  output logic                    valid_o,
  output ssct_pkg::ssct_res_t     res_o
);

  localparam int NW    = ssct_pkg::NW;
  localparam int AW    = ssct_pkg::AW;
  localparam int QX    = ssct_pkg::QX;
  localparam int TimeW = ssct_pkg::TimeW;
  localparam int Depth = NW + 3;

  typedef struct packed {
    logic          overlap;
    logic          go;
    logic [1:0]    neg;
    logic [AW-1:0] a;
  } dside_t;

  logic [Depth-1:0] vld_q;

  // Numerator stage: lane 0 is the earlier root, lane 1 the later one.
  logic signed [NW:0] xv, pv, mv;
  logic signed [NW:0] num_q [2];
  logic               ov_a_q, go_a_q;
  logic [AW-1:0]      a_a_q;

  // Sign and magnitude stage.
  logic [NW-1:0] mag_q [2];
  dside_t        sd_b_q;

  // Division stages.
  logic [NW-1:0] dnum_q [NW][2];
  logic [AW-1:0] drem_q [NW][2];
  logic [NW-1:0] dq_q   [NW][2];
  dside_t        dsd_q  [NW];
  logic [NW-1:0] dnum_in [NW][2];
  logic [AW-1:0] drem_in [NW][2];
  logic [NW-1:0] dq_in   [NW][2];
  dside_t        dsd_in  [NW];
  logic [AW:0]   dsh     [NW][2];
  logic          dtake   [NW][2];

  // Final rounding and clamping.
  logic [QX-1:0]      qq   [2];
  logic               sat  [2];
  logic [TimeW-1:0]   tval [2];
  ssct_pkg::ssct_res_t res_d, res_q;

  always_comb begin
    xv = $signed({1'b0, NW'(side_i.hmag) << ssct_pkg::TimeFracBits});
    if (side_i.hpos) begin
      xv = -xv;
    end
    pv = xv + $signed((NW+1)'(s_i));
    mv = xv - $signed((NW+1)'(s_i)) - $signed((NW+1)'(!exact_i));
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dnum_in[0][l] = mag_q[l];
      drem_in[0][l] = '0;
      dq_in[0][l]   = '0;
    end
    dsd_in[0] = sd_b_q;
    for (int i = 1; i < NW; i++) begin
      for (int l = 0; l < 2; l++) begin
        dnum_in[i][l] = dnum_q[i-1][l];
        drem_in[i][l] = drem_q[i-1][l];
        dq_in[i][l]   = dq_q[i-1][l];
      end
      dsd_in[i] = dsd_q[i-1];
    end
    for (int i = 0; i < NW; i++) begin
      for (int l = 0; l < 2; l++) begin
        dsh[i][l]   = {drem_in[i][l], dnum_in[i][l][NW-1-i]};
        dtake[i][l] = dsh[i][l] >= {1'b0, dsd_in[i].a};
      end
    end
  end

  // Floor of a negative quotient rounds its magnitude up when inexact.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qq[l] = QX'(dq_q[NW-1][l])
            + QX'(dsd_q[NW-1].neg[l] && (drem_q[NW-1][l] != '0));
      if (dsd_q[NW-1].neg[l]) begin
        sat[l]  = qq[l] > QX'(ssct_pkg::TimeMin);
        tval[l] = sat[l] ? ssct_pkg::TimeMin : TimeW'(-qq[l]);
      end else begin
        sat[l]  = qq[l] > QX'(ssct_pkg::TimeMax);
        tval[l] = sat[l] ? ssct_pkg::TimeMax : TimeW'(qq[l]);
      end
    end
    res_d = '0;
    if (dsd_q[NW-1].go) begin
      res_d.hit         = 1'b1;
      res_d.first_time  = tval[0];
      res_d.second_time = tval[1];
      res_d.saturated   = sat[0] || sat[1];
    end else if (dsd_q[NW-1].overlap) begin
      res_d.hit              = 1'b1;
      res_d.overlap_at_start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= mv;
      num_q[1] <= pv;
      ov_a_q   <= side_i.overlap;
      go_a_q   <= side_i.go;
      a_a_q    <= side_i.a;

      for (int l = 0; l < 2; l++) begin
        mag_q[l]      <= num_q[l][NW] ? NW'(-num_q[l]) : NW'(num_q[l]);
        sd_b_q.neg[l] <= num_q[l][NW];
      end
      sd_b_q.overlap <= ov_a_q;
      sd_b_q.go      <= go_a_q;
      sd_b_q.a       <= a_a_q;

      for (int i = 0; i < NW; i++) begin
        for (int l = 0; l < 2; l++) begin
          dnum_q[i][l] <= dnum_in[i][l];
          drem_q[i][l] <= dtake[i][l] ? AW'(dsh[i][l] - {1'b0, dsd_in[i].a})
                                      : AW'(dsh[i][l]);
          dq_q[i][l]   <= dtake[i][l] ? (dq_in[i][l] | (NW'(1) << (NW - 1 - i)))
                                      : dq_in[i][l];
        end
        dsd_q[i] <= dsd_in[i];
      end

      res_q <= res_d;
    end
  end

  assign valid_o = vld_q[Depth-1];
  assign res_o   = res_q;

endmodule

// ===== bench/ssct_contact_checker.sv =====
// Checker that predicts swept circle contact results and compares them on out_o.
`timescale 1ns / 1ps

module ssct_contact_checker (
  input  logic clk_i,
  ssct_in_if   in_c,
  ssct_out_if  out_c,
  output int   errors_o,
  output int   pending_o,
  output int   hits_o,
  output int   overlaps_o,
  output int   clamps_o
);

  ssct_pkg::ssct_res_t contact_q[$];

  function automatic logic [127:0] isqrt128(logic [127:0] n);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  // Floor of num/den, clamped to the Q16.16 range; clamp flags saturation.
  function automatic logic [ssct_pkg::TimeW-1:0] floor_time(logic signed [127:0] num,
                                                            logic signed [127:0] den,
                                                            inout logic clamp);
    logic signed [127:0] q;
    q = num / den;
    if (num < 0 && (num % den) != 0) q = q - 1;
    if (q > 128'sh7FFF_FFFF) begin
      clamp = 1'b1;
      return ssct_pkg::TimeMax;
    end
    if (q < -128'sh8000_0000) begin
      clamp = 1'b1;
      return ssct_pkg::TimeMin;
    end
    return q[ssct_pkg::TimeW-1:0];
  endfunction

  function automatic ssct_pkg::ssct_res_t predict_contact(ssct_pkg::ssct_item_t it);
    ssct_pkg::ssct_res_t r;
    longint abx, aby, vx, vy, h, rr, vv, ab2, hmag;
    logic [127:0] h2, ac, y, s, sc;
    logic signed [127:0] xs, pnum, mnum;
    logic clamp;
    r = '0;
    abx = longint'(it.b_start_x) - longint'(it.a_start_x);
    aby = longint'(it.b_start_y) - longint'(it.a_start_y);
    vx = (longint'(it.b_end_x) - longint'(it.b_start_x))
       - (longint'(it.a_end_x) - longint'(it.a_start_x));
    vy = (longint'(it.b_end_y) - longint'(it.b_start_y))
       - (longint'(it.a_end_y) - longint'(it.a_start_y));
    rr = (longint'(it.radius_a) + longint'(it.radius_b));
    rr = rr * rr;
    vv = vx * vx + vy * vy;
    ab2 = abx * abx + aby * aby;
    h = vx * abx + vy * aby;
    hmag = (h < 0) ? -h : h;
    if (ab2 <= rr) begin
      r.hit = 1'b1;
      r.overlap_at_start = 1'b1;
      return r;
    end
    if (vv == 0) return r;
    h2 = 128'(hmag) * 128'(hmag);
    ac = 128'(vv) * 128'(ab2 - rr);
    if (h2 < ac) return r;
    y = (h2 - ac) << (2 * ssct_pkg::TimeFracBits);
    s = isqrt128(y);
    sc = (s * s == y) ? s : s + 1;
    xs = $signed(128'(hmag) << ssct_pkg::TimeFracBits);
    if (h > 0) xs = -xs;
    // xs now holds -h scaled; roots are (-h -+ sqrt) / a.
    pnum = xs + $signed(s);
    mnum = xs - $signed(sc);
    clamp = 1'b0;
    r.hit = 1'b1;
    r.first_time = floor_time(mnum, $signed(128'(vv)), clamp);
    r.second_time = floor_time(pnum, $signed(128'(vv)), clamp);
    r.saturated = clamp;
    return r;
  endfunction

  initial begin
    errors_o = 0;
    pending_o = 0;
    hits_o = 0;
    overlaps_o = 0;
    clamps_o = 0;
  end

  always @(posedge clk_i) begin
    ssct_pkg::ssct_item_t it;
    ssct_pkg::ssct_res_t exp_r;
    if (in_c.valid && in_c.ready) begin
      it.radius_a  = in_c.radius_a;
      it.a_start_x = in_c.a_start_x;
      it.a_start_y = in_c.a_start_y;
      it.a_end_x   = in_c.a_end_x;
      it.a_end_y   = in_c.a_end_y;
      it.radius_b  = in_c.radius_b;
      it.b_start_x = in_c.b_start_x;
      it.b_start_y = in_c.b_start_y;
      it.b_end_x   = in_c.b_end_x;
      it.b_end_y   = in_c.b_end_y;
      contact_q.push_back(predict_contact(it));
    end
    if (out_c.valid && out_c.ready) begin
      if (contact_q.size() == 0) begin
        $error("result beat with no pair pending");
        errors_o <= errors_o + 1;
      end else begin
        exp_r = contact_q.pop_front();
        hits_o <= hits_o + exp_r.hit;
        overlaps_o <= overlaps_o + exp_r.overlap_at_start;
        clamps_o <= clamps_o + exp_r.saturated;
        if (out_c.hit !== exp_r.hit ||
            out_c.overlap_at_start !== exp_r.overlap_at_start ||
            out_c.first_time !== exp_r.first_time ||
            out_c.second_time !== exp_r.second_time ||
            out_c.saturated !== exp_r.saturated) begin
          errors_o <= errors_o + 1;
          if (out_c.hit !== exp_r.hit)
            $error("hit: expected %0d, got %0d", exp_r.hit, out_c.hit);
          if (out_c.overlap_at_start !== exp_r.overlap_at_start)
            $error("overlap_at_start: expected %0d, got %0d",
                   exp_r.overlap_at_start, out_c.overlap_at_start);
          if (out_c.first_time !== exp_r.first_time)
            $error("first_time: expected %0d, got %0d",
                   $signed(exp_r.first_time), out_c.first_time);
          if (out_c.second_time !== exp_r.second_time)
            $error("second_time: expected %0d, got %0d",
                   $signed(exp_r.second_time), out_c.second_time);
          if (out_c.saturated !== exp_r.saturated)
            $error("saturated: expected %0d, got %0d",
                   exp_r.saturated, out_c.saturated);
        end
      end
    end
    pending_o <= contact_q.size();
  end

endmodule

// ===== bench/swept_sphere_collision_time_core_test.sv =====
// Testbench top: clock, reset, pair stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module swept_sphere_collision_time_core_test;

  logic clk_i;
  logic rst_ni;
  logic in_fire;
  logic long_hold_done;
  int   errors, pending, hits, overlaps, clamps, sent;

  ssct_in_if  in_c ();
  ssct_out_if out_c ();

  swept_sphere_collision_time_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_c),
    .out_o  (out_c)
  );

  ssct_contact_checker i_checker (
    .clk_i      (clk_i),
    .in_c       (in_c),
    .out_c      (out_c),
    .errors_o   (errors),
    .pending_o  (pending),
    .hits_o     (hits),
    .overlaps_o (overlaps),
    .clamps_o   (clamps)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) in_fire <= in_c.valid && in_c.ready;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  function automatic ssct_pkg::ssct_item_t make_pair(int ra, int ax0, int ay0, int ax1,
                                                     int ay1, int rb, int bx0, int by0,
                                                     int bx1, int by1);
    ssct_pkg::ssct_item_t it;
    it.radius_a  = ra[ssct_pkg::RadBits-1:0];
    it.a_start_x = ax0[ssct_pkg::CoordBits-1:0];
    it.a_start_y = ay0[ssct_pkg::CoordBits-1:0];
    it.a_end_x   = ax1[ssct_pkg::CoordBits-1:0];
    it.a_end_y   = ay1[ssct_pkg::CoordBits-1:0];
    it.radius_b  = rb[ssct_pkg::RadBits-1:0];
    it.b_start_x = bx0[ssct_pkg::CoordBits-1:0];
    it.b_start_y = by0[ssct_pkg::CoordBits-1:0];
    it.b_end_x   = bx1[ssct_pkg::CoordBits-1:0];
    it.b_end_y   = by1[ssct_pkg::CoordBits-1:0];
    return it;
  endfunction

  // Mostly pairs close enough to meet during the frame; the rest is raw noise.
  function automatic ssct_pkg::ssct_item_t random_pair();
    int cx, cy, sp;
    if ($urandom_range(0, 3) == 0)
      return make_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
    sp = ($urandom_range(0, 4) == 0) ? 20000 : 400;
    cx = $urandom_range(0, 60000) - 30000;
    cy = $urandom_range(0, 60000) - 30000;
    return make_pair($urandom_range(0, sp / 4),
                     cx + $urandom_range(0, sp) - sp / 2,
                     cy + $urandom_range(0, sp) - sp / 2,
                     cx + $urandom_range(0, 2 * sp) - sp,
                     cy + $urandom_range(0, 2 * sp) - sp,
                     $urandom_range(0, sp / 4),
                     cx + $urandom_range(0, 2 * sp) - sp,
                     cy + $urandom_range(0, 2 * sp) - sp,
                     cx + $urandom_range(0, 2 * sp) - sp,
                     cy + $urandom_range(0, 2 * sp) - sp);
  endfunction

  task automatic send_pair(ssct_pkg::ssct_item_t it);
    in_c.valid     = 1'b1;
    in_c.radius_a  = it.radius_a;
    in_c.a_start_x = it.a_start_x;
    in_c.a_start_y = it.a_start_y;
    in_c.a_end_x   = it.a_end_x;
    in_c.a_end_y   = it.a_end_y;
    in_c.radius_b  = it.radius_b;
    in_c.b_start_x = it.b_start_x;
    in_c.b_start_y = it.b_start_y;
    in_c.b_end_x   = it.b_end_x;
    in_c.b_end_y   = it.b_end_y;
    do @(negedge clk_i); while (!in_fire);
    sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_c.valid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Receiver: one long hold early on so the pipe fills, then random stalls.
  initial begin
    int n;
    out_c.ready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    out_c.ready = 1'b1;
    repeat (60) @(negedge clk_i);
    out_c.ready = 1'b0;
    repeat (400) @(negedge clk_i);
    long_hold_done = 1'b1;
    forever begin
      out_c.ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_c.ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
    end
  end

  ssct_pkg::ssct_item_t directed[$];

  initial begin
    in_c.valid = 1'b0;
    in_c.radius_a = '0;
    in_c.a_start_x = '0;
    in_c.a_start_y = '0;
    in_c.a_end_x = '0;
    in_c.a_end_y = '0;
    in_c.radius_b = '0;
    in_c.b_start_x = '0;
    in_c.b_start_y = '0;
    in_c.b_end_x = '0;
    in_c.b_end_y = '0;
    sent = 0;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Overlap at start with zero radii, then maximum radii meeting head-on.
    directed.push_back(make_pair(0, 0, 0, 5, 5, 0, 0, 0, 9, 9));
    directed.push_back(make_pair(32767, -32768, -32768, 32767, 32767,
                                 32767, 32767, 32767, -32768, -32768));
    // Separated with no relative motion.
    directed.push_back(make_pair(1, 0, 0, 100, 50, 1, 10, 0, 110, 50));
    // Paths that miss: complex roots.
    directed.push_back(make_pair(1, 0, 0, 0, 0, 1, 10, 50, -10, 50));
    // Touching: a double root.
    directed.push_back(make_pair(1, 0, 0, 0, 0, 1, 10, 2, -10, 2));
    // Head-on contact inside the frame.
    directed.push_back(make_pair(5, 0, 0, 0, 0, 5, 100, 0, -100, 0));
    // Contact already behind both circles and far ahead.
    directed.push_back(make_pair(1, 0, 0, 0, 0, 1, -10, 0, -20, 0));
    directed.push_back(make_pair(1, 0, 0, 0, 0, 1, 30000, 0, 29999, 0));
    // Extreme offsets and slow motion: a miss and a clamped time; then fast crossing paths.
    directed.push_back(make_pair(0, -32768, -32768, -32768, -32768,
                                 0, 32767, 32767, 32766, 32767));
    directed.push_back(make_pair(0, -32768, 0, -32767, 0, 0, 32767, 0, 32767, 0));
    directed.push_back(make_pair(0, 32767, 32767, -32768, -32768,
                                 0, -32768, -32768, 32767, 32767));
    directed.push_back(make_pair(32767, -32768, 32767, 32767, -32768,
                                 0, 32767, -32768, -32768, 32767));
    directed.push_back(make_pair(3, 7, -9, -4, 11, 2, -6, 8, 13, -5));
    foreach (directed[i]) begin
      send_pair(directed[i]);
      idle_gap(gap_len());
    end

    for (int i = 0; i < 400; i++) begin
      if (i == 200) begin
        // Drain the pipe completely once before going on.
        in_c.valid = 1'b0;
        wait (long_hold_done && pending == 0);
        @(negedge clk_i);
      end
      send_pair(random_pair());
      if (i % 50 < 10) idle_gap(0);
      else idle_gap(gap_len());
    end
    in_c.valid = 1'b0;

    wait (pending == 0);
    repeat (130) @(negedge clk_i);
    $display("Sent %0d pairs: %0d hits, %0d overlapping at start, %0d clamped.",
             sent, hits, overlaps, clamps);
    $display("Covered overlap, motionless, missing, touching and clamping pairs.");
    if (errors == 0 && pending == 0) begin
      $display("swept_sphere_collision_time_core verification clean");
    end else begin
      $display("swept_sphere_collision_time_core verification failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("swept_sphere_collision_time_core verification failed");
    $finish;
  end

endmodule
